// File: rtl/core/lsscc_pkg.sv
`default_nettype none

package lsscc_pkg;

  // Command carried in the tuser field of each request.
  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_OPEN  = 2'd1,
    CMD_CLOSE = 2'd2,
    CMD_HALT  = 2'd3
  } cmd_e;

  // Motion state, one-hot. Encoded to the motor_state code on the output.
  typedef enum logic [6:0] {
    ST_IDLE             = 7'b0000001,
    ST_OPENING          = 7'b0000010,
    ST_CLOSING          = 7'b0000100,
    ST_START_OPEN_FAIL  = 7'b0001000,
    ST_START_CLOSE_FAIL = 7'b0010000,
    ST_OPEN_FAIL        = 7'b0100000,
    ST_CLOSE_FAIL       = 7'b1000000
  } motion_e;

  // motor_state codes
  localparam logic [2:0] MS_IDLE             = 3'd0;
  localparam logic [2:0] MS_OPENING          = 3'd1;
  localparam logic [2:0] MS_CLOSING          = 3'd2;
  localparam logic [2:0] MS_START_OPEN_FAIL  = 3'd3;
  localparam logic [2:0] MS_START_CLOSE_FAIL = 3'd4;
  localparam logic [2:0] MS_OPEN_FAIL        = 3'd5;
  localparam logic [2:0] MS_CLOSE_FAIL       = 3'd6;

  // cover_status codes
  localparam logic [2:0] CS_ABSENT  = 3'd0;
  localparam logic [2:0] CS_MOVING  = 3'd1;
  localparam logic [2:0] CS_OPEN    = 3'd2;
  localparam logic [2:0] CS_CLOSED  = 3'd3;
  localparam logic [2:0] CS_ERROR   = 3'd4;
  localparam logic [2:0] CS_UNKNOWN = 3'd5;

  // Configuration register indexes
  localparam logic REG_STEP_LIMIT  = 1'b0;
  localparam logic REG_START_CHECK = 1'b1;

  // Input item, less the command.
  typedef struct packed {
    logic closed_switch;
    logic open_switch;
    logic cover_present;
  } sense_t;

  // Result item, packed as it leaves on tdata (accepted in bit 0).
  typedef struct packed {
    logic [2:0] cover_status;
    logic [2:0] motor_state;
    logic       direction;
    logic       motor_enable;
    logic       step_pulse;
    logic       accepted;
  } result_t;

  // Motor control state, less the step counter.
  typedef struct packed {
    motion_e motion;
    logic    enable;
    logic    direction;
  } ctrl_t;

  function automatic logic [2:0] motor_code(motion_e st);
    logic [2:0] code;
    unique case (st)
      ST_IDLE:             code = MS_IDLE;
      ST_OPENING:          code = MS_OPENING;
      ST_CLOSING:          code = MS_CLOSING;
      ST_START_OPEN_FAIL:  code = MS_START_OPEN_FAIL;
      ST_START_CLOSE_FAIL: code = MS_START_CLOSE_FAIL;
      ST_OPEN_FAIL:        code = MS_OPEN_FAIL;
      ST_CLOSE_FAIL:       code = MS_CLOSE_FAIL;
      default:             code = MS_IDLE;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/limit_switched_stepper_cover_control_unit.sv
// Channel | Dir | Signals                       | Contents
// s_axis  | in  | tvalid tready tdata[7:0] tuser | tdata: present, open sw, closed sw;
//         |     |                               | tuser: command
// m_axis  | out | tvalid tready tdata[15:0]     | accepted, pulse, enable, direction,
//         |     |                               | motor_state[2:0], cover_status[2:0]
// cfg     | in  | we idx data                   | 0 step_limit, 1 start_check_step
//
// One request per cycle sustained while results are taken; a request passes through
// the input register, then the result register. Control state commits as a request
// leaves the input register, so each request sees the effect of the last.
// Reset clears motion state, counter, enable and direction; step_limit resets
// to all ones and start_check_step to 100.
// A stalled result holds the input register; s_axis_tready drops only when both are full.
`default_nettype none

module limit_switched_stepper_cover_control_unit
  import lsscc_pkg::*;
#(
  parameter int COUNT_BITS = 24
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // request stream
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [7:0]            s_axis_tdata,  // [0] cover_present, [1] open_switch,
                                                    // [2] closed_switch, [7:3] zero
  input  wire logic [1:0]            s_axis_tuser,  // [1:0] command
  // result stream
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [15:0]                m_axis_tdata,  // [0] accepted, [1] step_pulse,
                                                    // [2] motor_enable, [3] direction,
                                                    // [6:4] motor_state, [9:7] cover_status,
                                                    // [15:10] zero
  // configuration writes
  input  wire logic                  cfg_we_i,
  input  wire logic                  cfg_idx_i,
  input  wire logic [COUNT_BITS-1:0] cfg_data_i
);

  // input register
  logic   in_valid_q;
  cmd_e   in_cmd_q;
  sense_t in_sense_q;

  // result register
  logic    out_valid_q;
  result_t out_res_q;

  // control state and configuration
  ctrl_t                 ctrl_q, ctrl_d;
  logic [COUNT_BITS:0]   count_q, count_d;
  logic [COUNT_BITS-1:0] step_limit_q;
  logic [COUNT_BITS-1:0] start_check_q;
  result_t               res_d;

  logic fire;  // request moves from input to result register

  assign fire          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_cmd_q   <= cmd_e'(s_axis_tuser);
      in_sense_q <= sense_t'(s_axis_tdata[2:0]);
    end
  end

  lsscc_step #(
    .COUNT_BITS(COUNT_BITS)
  ) u_step (
    .cmd_i        (in_cmd_q),
    .sense_i      (in_sense_q),
    .ctrl_i       (ctrl_q),
    .count_i      (count_q),
    .step_limit_i (step_limit_q),
    .start_check_i(start_check_q),
    .ctrl_o       (ctrl_d),
    .count_o      (count_d),
    .result_o     (res_d)
  );

  // control state commits only when a request is processed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q.motion    <= ST_IDLE;
      ctrl_q.enable    <= 1'b0;
      ctrl_q.direction <= 1'b0;
      count_q          <= '0;
    end else if (fire) begin
      ctrl_q  <= ctrl_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_limit_q  <= '1;
      start_check_q <= COUNT_BITS'(100);
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_STEP_LIMIT) begin
        step_limit_q <= cfg_data_i;
      end
      if (cfg_idx_i == REG_START_CHECK) begin
        start_check_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_res_q};

endmodule

`default_nettype wire

// File: rtl/core/lsscc_step.sv
`default_nettype none

module lsscc_step
  import lsscc_pkg::*;
#(
  parameter int COUNT_BITS = 24
) (
  input  cmd_e                  cmd_i,
  input  sense_t                sense_i,
  input  ctrl_t                 ctrl_i,
  input  logic [COUNT_BITS:0]   count_i,
  input  logic [COUNT_BITS-1:0] step_limit_i,
  input  logic [COUNT_BITS-1:0] start_check_i,
  output ctrl_t                 ctrl_o,
  output logic [COUNT_BITS:0]   count_o,
  output result_t               result_o
);

  logic                moving;
  logic                moving_next;
  logic                closing;
  logic                target_sw;
  logic                start_sw;
  logic [COUNT_BITS:0] count_inc;
  logic                accepted;
  logic                pulse;
  logic [2:0]          cover_status;

  assign moving  = (ctrl_i.motion == ST_OPENING) || (ctrl_i.motion == ST_CLOSING);
  assign closing = (ctrl_i.motion == ST_CLOSING);
  assign target_sw = closing ? sense_i.closed_switch : sense_i.open_switch;
  assign start_sw  = closing ? sense_i.open_switch : sense_i.closed_switch;
  // saturating increment
  assign count_inc = (&count_i) ? count_i : count_i + 1'b1;

  always_comb begin
    ctrl_o   = ctrl_i;
    count_o  = count_i;
    accepted = 1'b0;
    pulse    = 1'b0;
    unique case (cmd_i)
      CMD_TICK: begin
        if (!moving) begin
          ctrl_o.enable = 1'b0;
        end else begin
          pulse   = 1'b1;
          count_o = count_inc;
          if (target_sw) begin
            ctrl_o.motion = ST_IDLE;
            ctrl_o.enable = 1'b0;
          end else if (count_inc == {1'b0, start_check_i} && start_sw) begin
            ctrl_o.motion = closing ? ST_START_CLOSE_FAIL : ST_START_OPEN_FAIL;
            ctrl_o.enable = 1'b0;
          end else if (count_inc > {1'b0, step_limit_i}) begin
            ctrl_o.motion = closing ? ST_CLOSE_FAIL : ST_OPEN_FAIL;
            ctrl_o.enable = 1'b0;
          end
        end
      end
      CMD_OPEN: begin
        if (sense_i.cover_present && !sense_i.open_switch) begin
          accepted = 1'b1;
          if (ctrl_i.motion != ST_OPENING) begin
            ctrl_o.motion    = ST_OPENING;
            ctrl_o.enable    = 1'b1;
            ctrl_o.direction = 1'b1;
            count_o          = '0;
          end
        end
      end
      CMD_CLOSE: begin
        if (sense_i.cover_present && !sense_i.closed_switch) begin
          accepted = 1'b1;
          if (ctrl_i.motion != ST_CLOSING) begin
            ctrl_o.motion    = ST_CLOSING;
            ctrl_o.enable    = 1'b1;
            ctrl_o.direction = 1'b0;
            count_o          = '0;
          end
        end
      end
      CMD_HALT: begin
        ctrl_o.enable = 1'b0;
        if (moving) begin
          ctrl_o.motion = ST_IDLE;
        end
      end
      default: begin
        ctrl_o.enable = 1'b0;
      end
    endcase
  end

  // status is taken from the state after this request
  assign moving_next = (ctrl_o.motion == ST_OPENING) || (ctrl_o.motion == ST_CLOSING);

  always_comb begin
    if (!sense_i.cover_present) begin
      cover_status = CS_ABSENT;
    end else if (moving_next) begin
      cover_status = CS_MOVING;
    end else if (sense_i.open_switch && !sense_i.closed_switch) begin
      cover_status = CS_OPEN;
    end else if (sense_i.closed_switch && !sense_i.open_switch) begin
      cover_status = CS_CLOSED;
    end else if (sense_i.open_switch && sense_i.closed_switch) begin
      cover_status = CS_ERROR;
    end else begin
      cover_status = CS_UNKNOWN;
    end
  end

  assign result_o.accepted     = accepted;
  assign result_o.step_pulse   = pulse;
  assign result_o.motor_enable = ctrl_o.enable;
  assign result_o.direction    = ctrl_o.direction;
  assign result_o.motor_state  = motor_code(ctrl_o.motion);
  assign result_o.cover_status = cover_status;

endmodule

`default_nettype wire

// File: tb/sv/lsscc_cover_checker.sv
`timescale 1ns / 1ps

module lsscc_cover_checker
  import lsscc_pkg::*;
#(
  parameter int COUNT_BITS = 24
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  input  wire logic                  s_axis_tready,
  input  wire logic [7:0]            s_axis_tdata,   // [0] present, [1] open sw, [2] closed sw
  input  wire logic [1:0]            s_axis_tuser,   // [1:0] command
  input  wire logic                  m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  input  wire logic [15:0]           m_axis_tdata,   // result_t in [9:0]
  input  wire logic                  cfg_we_i,
  input  wire logic                  cfg_idx_i,
  input  wire logic [COUNT_BITS-1:0] cfg_data_i,
  output int                         fail_count_o,
  output int                         pending_o
);

  // Shadow of the controller state and its registers.
  logic [COUNT_BITS-1:0] step_limit_q   = '1;
  logic [COUNT_BITS-1:0] start_check_q  = COUNT_BITS'(100);
  logic [2:0]            motor_q        = MS_IDLE;
  logic [COUNT_BITS:0]   steps_q        = '0;
  logic                  enable_q       = 1'b0;
  logic                  dir_q          = 1'b0;

  result_t expected_results[$];

  function automatic logic is_moving(logic [2:0] ms);
    return (ms == MS_OPENING) || (ms == MS_CLOSING);
  endfunction

  // Applies one request to the shadow state and returns the result it must produce.
  task automatic advance_cover(input cmd_e cmd, input sense_t s, output result_t r);
    logic       opening, closing, target_sw, start_sw;
    logic [2:0] want;
    r = '0;
    case (cmd) inside
      CMD_TICK: begin
        if (!is_moving(motor_q)) begin
          enable_q = 1'b0;
        end else begin
          closing   = (motor_q == MS_CLOSING);
          target_sw = closing ? s.closed_switch : s.open_switch;
          start_sw  = closing ? s.open_switch : s.closed_switch;
          if (steps_q != '1) steps_q = steps_q + 1'b1;
          if (target_sw) begin
            motor_q  = MS_IDLE;
            enable_q = 1'b0;
          end else if (steps_q == {1'b0, start_check_q} && start_sw) begin
            motor_q  = closing ? MS_START_CLOSE_FAIL : MS_START_OPEN_FAIL;
            enable_q = 1'b0;
          end else if (steps_q > {1'b0, step_limit_q}) begin
            motor_q  = closing ? MS_CLOSE_FAIL : MS_OPEN_FAIL;
            enable_q = 1'b0;
          end
          r.step_pulse = 1'b1;
        end
      end
      CMD_OPEN, CMD_CLOSE: begin
        opening   = (cmd == CMD_OPEN);
        want      = opening ? MS_OPENING : MS_CLOSING;
        target_sw = opening ? s.open_switch : s.closed_switch;
        if (s.cover_present && !target_sw) begin
          r.accepted = 1'b1;
          if (motor_q != want) begin
            motor_q  = want;
            steps_q  = '0;
            dir_q    = opening;
            enable_q = 1'b1;
          end
        end
      end
      default: begin
        enable_q = 1'b0;
        if (is_moving(motor_q)) motor_q = MS_IDLE;
      end
    endcase
    r.motor_enable = enable_q;
    r.direction    = dir_q;
    r.motor_state  = motor_q;
    if (!s.cover_present)                        r.cover_status = CS_ABSENT;
    else if (is_moving(motor_q))                 r.cover_status = CS_MOVING;
    else if (s.open_switch && !s.closed_switch)  r.cover_status = CS_OPEN;
    else if (s.closed_switch && !s.open_switch)  r.cover_status = CS_CLOSED;
    else if (s.open_switch && s.closed_switch)   r.cover_status = CS_ERROR;
    else                                         r.cover_status = CS_UNKNOWN;
  endtask

  task automatic check_field(string name, logic [2:0] exp_v, logic [2:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i) begin
    result_t want, got;
    if (!rst_ni) begin
      step_limit_q  = '1;
      start_check_q = COUNT_BITS'(100);
      motor_q       = MS_IDLE;
      steps_q       = '0;
      enable_q      = 1'b0;
      dir_q         = 1'b0;
      expected_results.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_STEP_LIMIT) step_limit_q = cfg_data_i;
        else                             start_check_q = cfg_data_i;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        advance_cover(cmd_e'(s_axis_tuser), sense_t'(s_axis_tdata[2:0]), want);
        expected_results.push_back(want);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = result_t'(m_axis_tdata[9:0]);
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding: tdata %h", m_axis_tdata);
          fail_count_o++;
        end else begin
          want = expected_results.pop_front();
          check_field("accepted", want.accepted, got.accepted);
          check_field("step_pulse", want.step_pulse, got.step_pulse);
          check_field("motor_enable", want.motor_enable, got.motor_enable);
          check_field("direction", want.direction, got.direction);
          check_field("motor_state", want.motor_state, got.motor_state);
          check_field("cover_status", want.cover_status, got.cover_status);
        end
      end
    end
    pending_o = expected_results.size();
  end

endmodule

// File: tb/sv/tb_limit_switched_stepper_cover_control_unit.sv
`timescale 1ns / 1ps

module tb_limit_switched_stepper_cover_control_unit;
  import lsscc_pkg::*;

  localparam int COUNT_BITS  = 24;
  // Far above the slowest legal run: ~850 requests, each waiting out sender
  // gaps and a receiver that stalls most of the time.
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 130;

  logic clk_i;
  logic rst_ni = 1'b0;

  // request side
  logic   s_valid = 1'b0;
  cmd_e   s_cmd   = CMD_TICK;
  sense_t s_sense = '0;
  logic   s_axis_tready;

  // result side
  logic        m_ready = 1'b0;
  logic        m_axis_tvalid;
  logic [15:0] m_axis_tdata;

  // register writes
  logic                  cfg_we   = 1'b0;
  logic                  cfg_idx  = REG_STEP_LIMIT;
  logic [COUNT_BITS-1:0] cfg_data = '0;

  int fails;
  int pending;
  int cycle_count   = 0;
  int sent          = 0;
  int settings_used = 0;
  int src_idle_pct  = 33;
  int sink_idle_pct = 73;
  int cur_lim       = 24'hFFFFFF;
  int cur_chk       = 100;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  limit_switched_stepper_cover_control_unit #(
    .COUNT_BITS(COUNT_BITS)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  ({5'b0, s_sense}),
    .s_axis_tuser  (s_cmd),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data)
  );

  lsscc_cover_checker #(
    .COUNT_BITS(COUNT_BITS)
  ) i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  ({5'b0, s_sense}),
    .s_axis_tuser  (s_cmd),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .fail_count_o  (fails),
    .pending_o     (pending)
  );

  // Receiver: ready is redrawn every falling edge, so stalls land on any
  // phase of the two-stage pipe.
  always @(negedge clk_i) begin
    m_ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic sense_t sense_of(logic present, logic open_sw, logic closed_sw);
    sense_t s;
    s.cover_present = present;
    s.open_switch   = open_sw;
    s.closed_switch = closed_sw;
    return s;
  endfunction

  // Switch levels seen from the direction of travel.
  function automatic sense_t travel_sense(logic present, logic opening,
                                          logic start_sw, logic target_sw);
    return opening ? sense_of(present, target_sw, start_sw)
                   : sense_of(present, start_sw, target_sw);
  endfunction

  // Offers one request at a falling edge, optionally after random idle
  // cycles, and returns at the falling edge after it was taken. valid is
  // left high so back-to-back requests never drop it.
  task automatic send_req(cmd_e cmd, sense_t s);
    while ($urandom_range(99) < src_idle_pct) begin
      s_valid <= 1'b0;
      @(negedge clk_i);
    end
    s_valid <= 1'b1;
    s_cmd   <= cmd;
    s_sense <= s;
    do @(posedge clk_i); while (!s_axis_tready);
    sent++;
    @(negedge clk_i);
  endtask

  // Stop offering, let every result come back, then let the pipe settle
  // before anything touches the registers.
  task automatic drain();
    s_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic program_regs(int step_limit, int start_check);
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_STEP_LIMIT;
    cfg_data <= COUNT_BITS'(step_limit);
    @(negedge clk_i);
    cfg_idx  <= REG_START_CHECK;
    cfg_data <= COUNT_BITS'(start_check);
    @(negedge clk_i);
    cfg_we   <= 1'b0;
    @(negedge clk_i);
    cur_lim = step_limit;
    cur_chk = start_check;
    settings_used++;
  endtask

  // One plausible move: request from the start end, then ticks while the
  // start switch releases at some step and the target closes at the last.
  // Lengths are kept near the start-check and step-limit counts so that
  // both failure kinds and normal arrival all come up.
  task automatic run_move();
    logic   opening;
    logic   present;
    int     cap;
    int     len;
    int     release_at;
    int     n;
    int     r;
    sense_t s;
    opening = $urandom_range(1);
    cap = 40;
    if (cur_chk + 4 < cap) cap = cur_chk + 4;
    if (cur_lim + 3 < cap) cap = cur_lim + 3;
    len        = $urandom_range(cap, 1);
    release_at = $urandom_range(cap + 2, 1);  // past len: start switch stuck
    present    = ($urandom_range(19) != 0);
    send_req(opening ? CMD_OPEN : CMD_CLOSE, travel_sense(present, opening, 1'b1, 1'b0));
    for (n = 1; n <= len; n++) begin
      r = $urandom_range(99);
      if (r < 3) begin
        send_req(CMD_HALT, travel_sense(1'b1, opening, n < release_at, 1'b0));
      end else if (r < 6) begin
        // repeat of the running request
        send_req(opening ? CMD_OPEN : CMD_CLOSE,
                 travel_sense(1'b1, opening, n < release_at, 1'b0));
      end else if (r < 8) begin
        // reversal mid-travel
        opening = !opening;
        send_req(opening ? CMD_OPEN : CMD_CLOSE, travel_sense(1'b1, opening, 1'b0, 1'b0));
      end
      s = travel_sense($urandom_range(9) != 0, opening, n < release_at, n == len);
      if ($urandom_range(19) == 0) s = sense_t'($urandom_range(7));  // switch glitch
      send_req(CMD_TICK, s);
    end
  endtask

  initial begin
    int lims[6];
    int chks[6];
    int ph;
    int stop_at;

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // ---- directed, reset register values ----
    send_req(CMD_TICK,  sense_of(0, 0, 0));  // tick while idle
    send_req(CMD_HALT,  sense_of(1, 1, 1));  // halt idle, both switches -> error
    send_req(CMD_OPEN,  sense_of(0, 0, 1));  // cover absent: refused
    send_req(CMD_OPEN,  sense_of(1, 1, 0));  // already open: refused
    send_req(CMD_CLOSE, sense_of(1, 0, 1));  // already closed: refused
    send_req(CMD_OPEN,  sense_of(1, 0, 1));  // starts opening
    send_req(CMD_OPEN,  sense_of(1, 0, 1));  // same direction: accepted, no restart
    send_req(CMD_TICK,  sense_of(1, 0, 1));  // step, start switch still closed
    send_req(CMD_TICK,  sense_of(1, 1, 0));  // target reached -> idle
    send_req(CMD_CLOSE, sense_of(1, 1, 0));
    send_req(CMD_HALT,  sense_of(1, 0, 0));  // halt a move -> idle, unknown status
    drain();

    // ---- directed, small counts: start and limit failures ----
    program_regs(2, 1);
    send_req(CMD_CLOSE, sense_of(1, 1, 0));
    send_req(CMD_TICK,  sense_of(1, 1, 0));  // start switch stuck -> start-close fail
    send_req(CMD_HALT,  sense_of(1, 1, 0));  // failure state kept
    send_req(CMD_TICK,  sense_of(1, 1, 0));  // no step out of a failure
    send_req(CMD_OPEN,  sense_of(1, 0, 0));  // restart from failure
    send_req(CMD_TICK,  sense_of(1, 0, 0));
    send_req(CMD_TICK,  sense_of(1, 0, 0));
    send_req(CMD_TICK,  sense_of(1, 0, 0));  // count passes limit -> open fail
    send_req(CMD_CLOSE, sense_of(1, 0, 0));
    send_req(CMD_OPEN,  sense_of(1, 0, 0));  // reversal
    send_req(CMD_TICK,  sense_of(0, 0, 1));  // presence ignored on tick -> start-open fail
    send_req(CMD_CLOSE, sense_of(0, 1, 0));  // absent: refused
    drain();

    // ---- directed, zero counts ----
    program_regs(0, 0);
    send_req(CMD_OPEN,  sense_of(1, 0, 1));
    send_req(CMD_TICK,  sense_of(1, 0, 1));  // first step already over the limit
    drain();

    // ---- random phases ----
    lims[0] = 24'hFFFFFF;               chks[0] = 100;
    lims[1] = 0;                        chks[1] = 0;
    lims[2] = 24'hFFFFFF;               chks[2] = 24'hFFFFFF;
    lims[3] = $urandom_range(30, 1);    chks[3] = $urandom_range(12, 1);
    lims[4] = $urandom_range(8, 0);     chks[4] = $urandom_range(6, 0);
    lims[5] = $urandom_range(60, 10);   chks[5] = $urandom_range(40, 1);

    for (ph = 0; ph < 6; ph++) begin
      // stall mix: sender-light/receiver-heavy, swapped, then none
      case (ph / 2)
        0: begin
          src_idle_pct  = 33;
          sink_idle_pct = 73;
        end
        1: begin
          src_idle_pct  = 73;
          sink_idle_pct = 33;
        end
        default: begin
          src_idle_pct  = 0;
          sink_idle_pct = 0;
        end
      endcase
      program_regs(lims[ph], chks[ph]);
      stop_at = sent + PHASE_ITEMS;
      while (sent < stop_at) begin
        if ($urandom_range(99) < 75) run_move();
        else send_req(cmd_e'($urandom_range(3)), sense_t'($urandom_range(7)));
      end
      drain();
    end

    repeat (8) @(negedge clk_i);
    $display("Run covered %0d requests: directed corner cases, random moves and noise",
             sent);
    $display("under %0d register settings and three stall mixes", settings_used);
    if (fails == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
